// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lti_pkg.sv =====
package lti_pkg;

  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 3;

  // Unity in Q1.12 and the lambda window edges in Q.24 (1.02 and 0.98).
  localparam logic [12:0] ONE_Q12    = 13'd4096;
  localparam logic [25:0] LAM_HI_Q24 = 26'd17112760;
  localparam logic [25:0] LAM_LO_Q24 = 26'd16441672;

  localparam logic signed [8:0]  COOLANT_THRESHOLD_RESET = 9'sd60;
  localparam logic [7:0]         ENABLE_DELAY_RESET      = 8'd5;
  localparam logic [12:0]        FILTER_COEF_RESET       = 13'd1229;
  localparam logic signed [13:0] TRIM_MIN_RESET          = -14'sd6400;
  localparam logic [12:0]        TRIM_MAX_RESET          = 13'd6400;
  localparam logic [10:0]        TRIM_STEP_RESET         = 11'd128;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COOLANT_THRESHOLD = 3'd0,
    REG_ENABLE_DELAY      = 3'd1,
    REG_FILTER_COEF       = 3'd2,
    REG_TRIM_MIN          = 3'd3,
    REG_TRIM_MAX          = 3'd4,
    REG_TRIM_STEP         = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic signed [8:0]  coolant_threshold;
    logic [7:0]         enable_delay;
    logic [12:0]        filter_coef;
    logic signed [13:0] trim_min;
    logic [12:0]        trim_max;
    logic [10:0]        trim_step;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] coolant_temp;
    logic              sensor_ready;
    logic              fuel_cutoff;
    logic              start_ended;
    logic [12:0]       lambda_meas;
  } sample_t;

  typedef struct packed {
    logic signed [13:0] trim_value;
    logic               loop_active;
  } result_t;

endpackage

// ===== rtl/core/lti_cfg.sv =====
module lti_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_en,
  input  logic [lti_pkg::CFG_INDEX_W-1:0]    write_index,
  input  logic [lti_pkg::CFG_DATA_W-1:0]     write_data,
  output lti_pkg::cfg_t                      cfg
);
  import lti_pkg::*;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coolant_threshold <= COOLANT_THRESHOLD_RESET;
      cfg.enable_delay      <= ENABLE_DELAY_RESET;
      cfg.filter_coef       <= FILTER_COEF_RESET;
      cfg.trim_min          <= TRIM_MIN_RESET;
      cfg.trim_max          <= TRIM_MAX_RESET;
      cfg.trim_step         <= TRIM_STEP_RESET;
    end else if (write_en) begin
      case (cfg_index_t'(write_index))
        REG_COOLANT_THRESHOLD: cfg.coolant_threshold <= $signed(write_data[8:0]);
        REG_ENABLE_DELAY:      cfg.enable_delay      <= write_data[7:0];
        REG_FILTER_COEF:       cfg.filter_coef       <= write_data[12:0];
        REG_TRIM_MIN:          cfg.trim_min          <= $signed(write_data[13:0]);
        REG_TRIM_MAX:          cfg.trim_max          <= write_data[12:0];
        REG_TRIM_STEP:         cfg.trim_step         <= write_data[10:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/lti_trim.sv =====
`include "assert_macros.svh"

module lti_trim (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  lti_pkg::sample_t sample,
  input  lti_pkg::cfg_t    cfg,
  output lti_pkg::result_t res
);
  import lti_pkg::*;

  logic [7:0]         delay_count;
  logic [7:0]         delay_count_next;
  logic               enable_prev;
  logic [12:0]        lambda_prev;
  logic signed [13:0] trim_acc;

  logic               enable;
  logic               active;
  logic [12:0]        coef;
  logic [12:0]        coef_prev;
  logic [25:0]        prod_cur;
  logic [25:0]        prod_prev;
  logic [25:0]        blend;
  logic signed [15:0] acc_ext;
  logic signed [15:0] step_ext;
  logic signed [15:0] lo_ext;
  logic signed [15:0] hi_ext;
  logic signed [15:0] stepped;
  logic signed [15:0] low_clamped;
  logic signed [15:0] clamped;

  always_comb begin
    enable = ($signed(sample.coolant_temp) > $signed(cfg.coolant_threshold)) &&
             !sample.fuel_cutoff && sample.sensor_ready && sample.start_ended;

    if (enable && !enable_prev) begin
      delay_count_next = cfg.enable_delay;
    end else if (delay_count != 8'd0) begin
      delay_count_next = delay_count - 8'd1;
    end else begin
      delay_count_next = delay_count;
    end
    active = enable && (delay_count_next == 8'd0);

    // Blend in Q.24; the two weights always add up to unity.
    coef      = (cfg.filter_coef > ONE_Q12) ? ONE_Q12 : cfg.filter_coef;
    coef_prev = ONE_Q12 - coef;
    prod_cur  = 26'(sample.lambda_meas) * 26'(coef);
    prod_prev = 26'(lambda_prev) * 26'(coef_prev);
    blend     = prod_cur + prod_prev;

    acc_ext  = {{2{trim_acc[13]}}, trim_acc};
    step_ext = $signed({5'b0, cfg.trim_step});
    lo_ext   = {{2{cfg.trim_min[13]}}, cfg.trim_min};
    hi_ext   = $signed({3'b0, cfg.trim_max});

    if (blend > LAM_HI_Q24) begin
      stepped = acc_ext + step_ext;
    end else if (blend < LAM_LO_Q24) begin
      stepped = acc_ext - step_ext;
    end else begin
      stepped = acc_ext;
    end

    // The upper clamp goes last, so it wins when the limits cross.
    low_clamped = (stepped < lo_ext) ? lo_ext : stepped;
    clamped     = (low_clamped > hi_ext) ? hi_ext : low_clamped;

    res.loop_active = active;
    res.trim_value  = active ? clamped[13:0] : 14'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_count <= 8'd0;
      enable_prev <= 1'b0;
      lambda_prev <= 13'd0;
      trim_acc    <= 14'sd0;
    end else if (step) begin
      delay_count <= delay_count_next;
      enable_prev <= enable;
      lambda_prev <= sample.lambda_meas;
      trim_acc    <= res.trim_value;
    end
  end

  `ASSERT_NEXT(a_trim_cleared, step && !active, trim_acc == 14'sd0, "trim not cleared when idle")
  `ASSERT_IMPLIES(a_upper_clamp, active, res.trim_value <= $signed({1'b0, cfg.trim_max}), "trim above upper clamp")
  `ASSERT_NEXT(a_delay_load, step && enable && !enable_prev, delay_count == $past(cfg.enable_delay), "delay not loaded on enable edge")

endmodule

// ===== rtl/core/lambda_trim_integrator_top.sv =====
// Closed-loop lambda fuel trim, one control tick per word.
//
// The sample channel (sample_valid, sample_ready, sample) carries one tick:
// coolant temperature, sensor-ready, fuel-cutoff and start-ended flags and
// the measured lambda. The result channel (result_valid, result_ready,
// result) returns one word per tick with the trim value and the loop-active
// flag. Both channels complete a transfer on a rising edge with valid and
// ready high. The write port (write_en, write_index, write_data) loads the
// six tuning registers and should only be used while no tick is in flight.
//
// A word accepted at a rising edge is held in the input register; its trim
// is computed there and captured in the result register when the pipeline
// advances. The block takes one word every cycle while the receiver keeps
// up; a single stage of blend multiplies, compares and clamp sits between them.
//
// A synchronous reset loads the register defaults, clears the loop state
// (delay counter, enable history, previous lambda, trim accumulator) and
// empties the pipeline. When the receiver stalls, the result word holds and
// the input register fills once more, after which sample_ready drops.
`include "assert_macros.svh"

module lambda_trim_integrator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  lti_pkg::sample_t                 sample,
  output logic                             result_valid,
  input  logic                             result_ready,
  output lti_pkg::result_t                 result,
  input  logic                             write_en,
  input  logic [lti_pkg::CFG_INDEX_W-1:0]  write_index,
  input  logic [lti_pkg::CFG_DATA_W-1:0]   write_data
);
  import lti_pkg::*;

  cfg_t    cfg;
  result_t res;

  // Input register in front of the trim logic.
  logic    stage_valid;
  sample_t stage_word;

  // The pipeline moves whenever the result register is empty or being drained.
  logic advance;
  logic step;

  assign advance      = !result_valid || result_ready;
  assign sample_ready = !stage_valid || advance;
  assign step         = stage_valid && advance;

  lti_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .cfg         (cfg)
  );

  // The loop state advances exactly when a tick moves into the result register.
  lti_trim u_trim (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (stage_word),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage_word <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= res;
    end
  end

  `ASSERT_NEXT(a_stage_held, stage_valid && !advance, stage_valid && $stable(stage_word), "input stage lost while stalled")
  `ASSERT_NEXT(a_result_loaded, step, result_valid, "computed word not presented")

endmodule
